[sv/fsra_pkg.sv]
// Shared types and constants of the flash sector run allocator.
// Depends on nothing; the interfaces, the allocator, the checker and the bench take names from here.
package fsra_pkg;

  localparam int NUM_SECTORS_DEF = 1024;
  localparam int MAX_REGION      = 1024;

  localparam int OP_W     = 3;
  localparam int SEC_W    = 10;
  localparam int BYTES_W  = 26;
  localparam int CNT_W    = 11;
  localparam int LOG2_W   = 5;
  localparam int STAT_W   = 2;
  localparam int SECST_W  = 2;
  localparam int NEED_W   = BYTES_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0]  RESET_DATA_SECTORS = 11'd1019;
  localparam logic [LOG2_W-1:0] RESET_SIZE_LOG2    = 5'd12;

  typedef enum logic [OP_W-1:0] {
    OP_FIND    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_REL_RSV = 3'd3,
    OP_COUNT   = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_BUSY   = 2'd3
  } status_t;

  typedef enum logic [SECST_W-1:0] {
    SEC_FREE = 2'd0,
    SEC_USED = 2'd1,
    SEC_RSV  = 2'd2
  } sec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_SECTORS = 1'd0,
    CFG_SIZE_LOG2    = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_FILL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SEC_W-1:0]   start_sector;
    logic [BYTES_W-1:0] request_bytes;
    logic               reserve;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [SEC_W-1:0]   found_sector;
    logic [CNT_W-1:0]   free_count;
    logic [STAT_W-1:0]  status;
  } rsp_t;

endpackage

[sv/fsra_req_if.sv]
// Request channel of the flash sector run allocator: valid/ready plus request.
// Depends on fsra_pkg for the request type.
interface fsra_req_if;
  logic             valid;
  logic             ready;
  fsra_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/fsra_rsp_if.sv]
// Result channel of the flash sector run allocator: valid/ready plus result.
// Depends on fsra_pkg for the result type.
interface fsra_rsp_if;
  logic             valid;
  logic             ready;
  fsra_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/fsra_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fsra_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/flash_sector_run_allocator.sv]
// Flash sector run allocator: a 2-bit status per sector (free, used, reserved)
// held in one RAM with a registered read, walked one sector per cycle.
// Depends on fsra_pkg, fsra_req_if, fsra_rsp_if and fsra_ram.
//
// Usage notes. Let L = min(data_sector_count, NUM_SECTORS, 1024). Every
// operation is handled one at a time; throughput is set by the single read
// port of the status RAM, which visits one sector per cycle. Find and count
// scan up to L sectors (find stops early at the first fitting run).
// Allocate and release make two passes: one pass checks the run, a second
// pass writes it. Release-reserved sweeps the whole map of
// min(NUM_SECTORS, 1024) sectors. A rejected request (zero length, run past
// the top, unknown operation) answers without a scan. After reset the block
// runs a clearing pass over min(NUM_SECTORS, 1024) sectors and then a
// free-count scan of L sectors; in_ch.ready stays low meanwhile. Writing
// data_sector_count queues the same free-count scan, which runs before the
// next request is taken. Configuration writes are taken in every cycle. A
// finished result sits in an output register, so the next request can be
// taken while the result waits for its transfer.
module flash_sector_run_allocator #(
  parameter int NUM_SECTORS = fsra_pkg::NUM_SECTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fsra_req_if.sink                       in_ch,
  fsra_rsp_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [fsra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsra_pkg::CNT_W-1:0]     cfg_data
);

  localparam int DEPTH = (NUM_SECTORS < fsra_pkg::MAX_REGION) ?
                         NUM_SECTORS : fsra_pkg::MAX_REGION;
  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_W   = fsra_pkg::CNT_W;
  localparam int SEC_W   = fsra_pkg::SEC_W;
  localparam int NEED_W  = fsra_pkg::NEED_W;
  localparam int BYTES_W = fsra_pkg::BYTES_W;
  localparam int LOG2_W  = fsra_pkg::LOG2_W;
  localparam int SECST_W = fsra_pkg::SECST_W;
  localparam int OP_W    = fsra_pkg::OP_W;
  localparam int STAT_W  = fsra_pkg::STAT_W;
  localparam int END_W   = NEED_W + 1;

  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] RESET_FREE =
    (fsra_pkg::RESET_DATA_SECTORS > DEPTH_C) ? DEPTH_C : fsra_pkg::RESET_DATA_SECTORS;

  // Control state
  fsra_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  dsc_r;
  logic [LOG2_W-1:0] log2_r;
  logic              rescan_pend_r, rescan_pend_nxt;
  logic              internal_r, internal_nxt;
  logic [CNT_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic [CNT_W-1:0]  iss_end_r, iss_end_nxt;
  logic              dv_r;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [SEC_W-1:0]   start_r, start_nxt;
  logic               reserve_r, reserve_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic [CNT_W-1:0]   d_idx_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SECST_W-1:0] fill_val_r, fill_val_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [SEC_W-1:0]   res_found_r, res_found_nxt;
  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  fsra_pkg::rsp_t     out_data_r, out_data_nxt;

  // Status RAM ports
  logic               rd_en;
  logic [AW-1:0]      raddr;
  logic [SECST_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      waddr;
  logic [SECST_W-1:0] wdata;

  // Helpers
  logic [CNT_W-1:0]  lim;
  logic              in_xfer;
  logic [NEED_W-1:0] round_sum;
  logic [NEED_W-1:0] need_c;
  logic [END_W-1:0]  run_end;
  logic              run_fits;
  logic              need_zero;
  logic              iss_busy;
  logic              scan_end;
  logic [CNT_W-1:0]  cnt_inc;
  logic              is_free, is_used, is_rsv;
  logic              find_hit;
  logic              chk_bad;

  assign lim = (dsc_r > DEPTH_C) ? DEPTH_C : dsc_r;

  assign in_ch.ready  = (state_r == fsra_pkg::S_IDLE) && !rescan_pend_r;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Round the byte count up to whole sectors. From 2^26-byte sectors on,
  // any nonzero request is one sector.
  always_comb begin
    round_sum = '0;
    need_c    = '0;
    if (log2_r >= LOG2_W'(BYTES_W)) begin
      need_c = NEED_W'(|in_ch.data.request_bytes);
    end else begin
      round_sum = {1'b0, in_ch.data.request_bytes} +
                  ((NEED_W'(1) << log2_r) - NEED_W'(1));
      need_c    = round_sum >> log2_r;
    end
  end

  assign need_zero = (need_r == '0);
  assign run_end   = END_W'(start_r) + END_W'(need_r);
  assign run_fits  = (run_end <= END_W'(lim));

  assign iss_busy = (iss_idx_r != iss_end_r);
  assign scan_end = !iss_busy && !dv_r;
  assign cnt_inc  = cnt_r + CNT_W'(1);

  assign is_free = (rd_data == fsra_pkg::SEC_FREE);
  assign is_used = (rd_data == fsra_pkg::SEC_USED);
  assign is_rsv  = (rd_data == fsra_pkg::SEC_RSV);

  assign find_hit = dv_r && (op_r == fsra_pkg::OP_FIND) && is_free &&
                    (NEED_W'(cnt_inc) == need_r);
  assign chk_bad  = dv_r && (((op_r == fsra_pkg::OP_ALLOC) && !is_free) ||
                             ((op_r == fsra_pkg::OP_RELEASE) && is_rsv));

  // Read side: one sector issued per cycle while a scan has addresses left.
  assign rd_en = (state_r == fsra_pkg::S_SCAN) && iss_busy;
  assign raddr = iss_idx_r[AW-1:0];

  // Write side: sweep writes in clear and fill, read-modify-write when
  // release-reserved sees a reserved sector at the data stage.
  always_comb begin
    wr_en = 1'b0;
    waddr = iss_idx_r[AW-1:0];
    wdata = fill_val_r;
    unique case (state_r)
      fsra_pkg::S_CLEAR: begin
        wr_en = iss_busy;
        wdata = fsra_pkg::SEC_FREE;
      end
      fsra_pkg::S_FILL: begin
        wr_en = iss_busy;
      end
      fsra_pkg::S_SCAN: begin
        if (dv_r && (op_r == fsra_pkg::OP_REL_RSV) && is_rsv) begin
          wr_en = 1'b1;
          waddr = d_idx_r[AW-1:0];
          wdata = fsra_pkg::SEC_FREE;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  fsra_ram #(
    .WIDTH (SECST_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsra_pkg::S_CLEAR: begin
        if (!iss_busy) begin
          state_nxt = fsra_pkg::S_IDLE;
        end
      end
      fsra_pkg::S_IDLE: begin
        if (rescan_pend_r || in_xfer) begin
          state_nxt = rescan_pend_r ? fsra_pkg::S_SCAN : fsra_pkg::S_PREP;
        end
      end
      fsra_pkg::S_PREP: begin
        case (op_r)
          fsra_pkg::OP_FIND: begin
            state_nxt = need_zero ? fsra_pkg::S_RESP : fsra_pkg::S_SCAN;
          end
          fsra_pkg::OP_ALLOC, fsra_pkg::OP_RELEASE: begin
            state_nxt = (need_zero || !run_fits) ? fsra_pkg::S_RESP : fsra_pkg::S_SCAN;
          end
          fsra_pkg::OP_REL_RSV, fsra_pkg::OP_COUNT: begin
            state_nxt = fsra_pkg::S_SCAN;
          end
          default: begin
            state_nxt = fsra_pkg::S_RESP;
          end
        endcase
      end
      fsra_pkg::S_SCAN: begin
        if (find_hit || chk_bad) begin
          state_nxt = fsra_pkg::S_RESP;
        end else if (scan_end) begin
          if ((op_r == fsra_pkg::OP_ALLOC) || (op_r == fsra_pkg::OP_RELEASE)) begin
            state_nxt = fsra_pkg::S_FILL;
          end else if (internal_r) begin
            state_nxt = fsra_pkg::S_IDLE;
          end else begin
            state_nxt = fsra_pkg::S_RESP;
          end
        end
      end
      fsra_pkg::S_FILL: begin
        if (!iss_busy) begin
          state_nxt = fsra_pkg::S_RESP;
        end
      end
      fsra_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = fsra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fsra_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and register updates per state
  always_comb begin
    rescan_pend_nxt = rescan_pend_r;
    internal_nxt    = internal_r;
    iss_idx_nxt     = iss_idx_r;
    iss_end_nxt     = iss_end_r;
    free_nxt        = free_r;
    out_valid_nxt   = out_valid_r;
    op_nxt          = op_r;
    start_nxt       = start_r;
    reserve_nxt     = reserve_r;
    need_nxt        = need_r;
    cnt_nxt         = cnt_r;
    fill_val_nxt    = fill_val_r;
    res_ok_nxt      = res_ok_r;
    res_found_nxt   = res_found_r;
    res_status_nxt  = res_status_r;
    out_data_nxt    = out_data_r;

    // Drop the result once its transfer completes.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fsra_pkg::S_CLEAR: begin
        if (iss_busy) begin
          iss_idx_nxt = iss_idx_r + CNT_W'(1);
        end
      end

      fsra_pkg::S_IDLE: begin
        if (rescan_pend_r) begin
          // Free-count reload with no result
          rescan_pend_nxt = 1'b0;
          internal_nxt    = 1'b1;
          op_nxt          = fsra_pkg::OP_COUNT;
          iss_idx_nxt     = '0;
          iss_end_nxt     = lim;
          cnt_nxt         = '0;
        end else if (in_xfer) begin
          internal_nxt = 1'b0;
          op_nxt       = in_ch.data.operation;
          start_nxt    = in_ch.data.start_sector;
          reserve_nxt  = in_ch.data.reserve;
          need_nxt     = need_c;
        end
      end

      fsra_pkg::S_PREP: begin
        cnt_nxt        = '0;
        res_ok_nxt     = 1'b0;
        res_found_nxt  = '0;
        res_status_nxt = fsra_pkg::STAT_RANGE;
        fill_val_nxt   = (op_r == fsra_pkg::OP_ALLOC) ?
                         (reserve_r ? fsra_pkg::SEC_RSV : fsra_pkg::SEC_USED) :
                         fsra_pkg::SEC_FREE;
        case (op_r)
          fsra_pkg::OP_ALLOC, fsra_pkg::OP_RELEASE: begin
            iss_idx_nxt = CNT_W'(start_r);
            iss_end_nxt = run_end[CNT_W-1:0];
          end
          fsra_pkg::OP_REL_RSV: begin
            iss_idx_nxt = '0;
            iss_end_nxt = DEPTH_C;
          end
          default: begin
            iss_idx_nxt = '0;
            iss_end_nxt = lim;
          end
        endcase
      end

      fsra_pkg::S_SCAN: begin
        if (rd_en) begin
          iss_idx_nxt = iss_idx_r + CNT_W'(1);
        end
        if (dv_r) begin
          case (op_r)
            fsra_pkg::OP_FIND: begin
              cnt_nxt = is_free ? cnt_inc : '0;
            end
            fsra_pkg::OP_RELEASE: begin
              if (is_used) begin
                cnt_nxt = cnt_inc;
              end
            end
            fsra_pkg::OP_REL_RSV: begin
              if (is_rsv && (d_idx_r < lim)) begin
                cnt_nxt = cnt_inc;
              end
            end
            fsra_pkg::OP_COUNT: begin
              if (is_free) begin
                cnt_nxt = cnt_inc;
              end
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
        if (find_hit) begin
          res_ok_nxt     = 1'b1;
          res_found_nxt  = SEC_W'(d_idx_r - cnt_r);
          res_status_nxt = fsra_pkg::STAT_OK;
        end else if (chk_bad) begin
          res_status_nxt = fsra_pkg::STAT_BUSY;
        end else if (scan_end) begin
          case (op_r)
            fsra_pkg::OP_FIND: begin
              res_status_nxt = fsra_pkg::STAT_NO_FIT;
            end
            fsra_pkg::OP_ALLOC, fsra_pkg::OP_RELEASE: begin
              // Run checked; rewind for the write pass.
              iss_idx_nxt = CNT_W'(start_r);
            end
            fsra_pkg::OP_REL_RSV: begin
              free_nxt       = free_r + cnt_r;
              res_ok_nxt     = 1'b1;
              res_status_nxt = fsra_pkg::STAT_OK;
            end
            default: begin
              free_nxt       = cnt_r;
              res_ok_nxt     = 1'b1;
              res_status_nxt = fsra_pkg::STAT_OK;
            end
          endcase
        end
      end

      fsra_pkg::S_FILL: begin
        if (iss_busy) begin
          iss_idx_nxt = iss_idx_r + CNT_W'(1);
        end else begin
          free_nxt       = (op_r == fsra_pkg::OP_ALLOC) ?
                           free_r - need_r[CNT_W-1:0] : free_r + cnt_r;
          res_ok_nxt     = 1'b1;
          res_status_nxt = fsra_pkg::STAT_OK;
        end
      end

      fsra_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.ok           = res_ok_r;
          out_data_nxt.found_sector = res_found_r;
          out_data_nxt.free_count   = free_r;
          out_data_nxt.status       = res_status_r;
        end
      end

      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase

    // A new region size needs a fresh free count; the write wins over a
    // scan that starts in the same cycle.
    if (cfg_we && (cfg_index == fsra_pkg::CFG_DATA_SECTORS)) begin
      rescan_pend_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fsra_pkg::S_CLEAR;
      rescan_pend_r <= 1'b1;
      internal_r    <= 1'b0;
      iss_idx_r     <= '0;
      iss_end_r     <= DEPTH_C;
      dv_r          <= 1'b0;
      free_r        <= RESET_FREE;
      out_valid_r   <= 1'b0;
      dsc_r         <= fsra_pkg::RESET_DATA_SECTORS;
      log2_r        <= fsra_pkg::RESET_SIZE_LOG2;
    end else begin
      state_r       <= state_nxt;
      rescan_pend_r <= rescan_pend_nxt;
      internal_r    <= internal_nxt;
      iss_idx_r     <= iss_idx_nxt;
      iss_end_r     <= iss_end_nxt;
      dv_r          <= rd_en;
      free_r        <= free_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          fsra_pkg::CFG_DATA_SECTORS: dsc_r  <= cfg_data;
          fsra_pkg::CFG_SIZE_LOG2:    log2_r <= cfg_data[LOG2_W-1:0];
          default:                    dsc_r  <= dsc_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    start_r      <= start_nxt;
    reserve_r    <= reserve_nxt;
    need_r       <= need_nxt;
    d_idx_r      <= iss_idx_r;
    cnt_r        <= cnt_nxt;
    fill_val_r   <= fill_val_nxt;
    res_ok_r     <= res_ok_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

[sv/fsra_checker.sv]
// Port-level checks of the flash sector run allocator, bound to its top level.
// Depends on fsra_pkg and flash_sector_run_allocator.
module fsra_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input fsra_pkg::rsp_t out_data
);

  // Coming out of reset, hold off requests and show no result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("fsra: ready or valid high right after reset");

  // Each accepted request drops ready in the cycle after its transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("fsra: request taken in the cycle after a transfer");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("fsra: stalled result changed or dropped");

  // Success and status agree; a failed request reports no sector.
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ok == (out_data.status == fsra_pkg::STAT_OK)) &&
                  (out_data.ok || (out_data.found_sector == '0)))
    else $error("fsra: ok, status and found sector disagree");

endmodule

bind flash_sector_run_allocator fsra_checker u_fsra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[bench/flash_sector_run_allocator_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for flash_sector_run_allocator: a sector map tracker predicts each result.
// Depends on fsra_pkg, fsra_req_if, fsra_rsp_if and the allocator RTL.
module flash_sector_run_allocator_tb;
  import fsra_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned END_WAIT       = 2100;   // longest single operation, rounded up
  localparam int unsigned RESET_UNIT     = 1 << RESET_SIZE_LOG2;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  // Shadow of the block: sector map, free count and registers, advanced on
  // every accepted request. It also answers the stimulus side's questions
  // (where is a free run, where is a used sector).
  class sector_allocation_tracker;
    sec_t              sector_map [NUM_SECTORS_DEF];
    int unsigned       free_total;
    logic [CNT_W-1:0]  data_sectors;
    logic [LOG2_W-1:0] size_log2;
    rsp_t              pending_results [$];
    int unsigned       mismatches, checked;
    int unsigned       n_ok, n_no_fit, n_range, n_busy;

    function new();
      foreach (sector_map[i]) sector_map[i] = SEC_FREE;
      data_sectors = RESET_DATA_SECTORS;
      size_log2    = RESET_SIZE_LOG2;
      free_total   = region_limit();
    endfunction

    function int unsigned region_limit();
      int unsigned lim;
      lim = data_sectors;
      if (lim > NUM_SECTORS_DEF) lim = NUM_SECTORS_DEF;
      if (lim > MAX_REGION) lim = MAX_REGION;
      return lim;
    endfunction

    function int unsigned free_in_region();
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < region_limit(); i++)
        if (sector_map[i] == SEC_FREE) n++;
      return n;
    endfunction

    function longint unsigned sectors_for_bytes(logic [BYTES_W-1:0] bytes);
      longint unsigned unit;
      unit = 64'd1 << size_log2;
      return (longint'(bytes) + unit - 1) >> size_log2;
    endfunction

    // Lowest start of a free run of the given length, or -1.
    function int first_free_run(longint unsigned need);
      int unsigned run;
      run = 0;
      for (int unsigned i = 0; i < region_limit(); i++) begin
        if (sector_map[i] == SEC_FREE) begin
          run++;
          if (run == need) return i + 1 - run;
        end else begin
          run = 0;
        end
      end
      return -1;
    endfunction

    // First sector in the region holding the given state, searched cyclically.
    function int find_sector(sec_t want, int unsigned from);
      int unsigned lim, idx;
      lim = region_limit();
      for (int unsigned k = 0; k < lim; k++) begin
        idx = (from + k) % lim;
        if (sector_map[idx] == want) return idx;
      end
      return -1;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CNT_W-1:0] value);
      case (idx)
        CFG_DATA_SECTORS: begin
          data_sectors = value;
          free_total   = free_in_region();  // reload from a rescan
        end
        CFG_SIZE_LOG2: size_log2 = value[LOG2_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      rsp_t            e;
      int unsigned     lim, stop, freed;
      longint unsigned need;
      int              hit;
      bit              refused;
      lim      = region_limit();
      need     = sectors_for_bytes(r.request_bytes);
      e        = '0;
      e.status = STAT_RANGE;
      case (r.operation)
        OP_FIND: begin
          if (need != 0) begin
            hit = first_free_run(need);
            if (hit < 0) begin
              e.status = STAT_NO_FIT;
            end else begin
              e.ok           = 1'b1;
              e.found_sector = SEC_W'(hit);
              e.status       = STAT_OK;
            end
          end
        end
        OP_ALLOC, OP_RELEASE: begin
          // A run ending exactly at the region top is legal.
          if (need != 0 && longint'(r.start_sector) + need <= lim) begin
            stop    = r.start_sector + int'(need);
            refused = 1'b0;
            for (int unsigned i = r.start_sector; i < stop; i++)
              if (r.operation == OP_ALLOC ? sector_map[i] != SEC_FREE
                                          : sector_map[i] == SEC_RSV)
                refused = 1'b1;
            if (refused) begin
              e.status = STAT_BUSY;
            end else begin
              freed = 0;
              for (int unsigned i = r.start_sector; i < stop; i++) begin
                if (r.operation == OP_ALLOC) begin
                  sector_map[i] = r.reserve ? SEC_RSV : SEC_USED;
                end else if (sector_map[i] == SEC_USED) begin
                  sector_map[i] = SEC_FREE;
                  freed++;
                end
              end
              if (r.operation == OP_ALLOC) free_total -= int'(need);
              else free_total += freed;
              e.ok     = 1'b1;
              e.status = STAT_OK;
            end
          end
        end
        OP_REL_RSV: begin
          // Reserved sectors above the region are freed but not counted.
          freed = 0;
          for (int unsigned i = 0; i < NUM_SECTORS_DEF; i++) begin
            if (sector_map[i] == SEC_RSV) begin
              sector_map[i] = SEC_FREE;
              if (i < lim) freed++;
            end
          end
          free_total += freed;
          e.ok     = 1'b1;
          e.status = STAT_OK;
        end
        OP_COUNT: begin
          free_total = free_in_region();
          e.ok       = 1'b1;
          e.status   = STAT_OK;
        end
        default: ;
      endcase
      e.free_count = CNT_W'(free_total);
      case (e.status)
        STAT_OK:     n_ok++;
        STAT_NO_FIT: n_no_fit++;
        STAT_RANGE:  n_range++;
        default:     n_busy++;
      endcase
      pending_results.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: ok %0d found %0d free %0d status %0d",
               got.ok, got.found_sector, got.free_count, got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("ok", want.ok, got.ok);
      compare_field("found_sector", want.found_sector, got.found_sector);
      compare_field("free_count", want.free_count, got.free_count);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  fsra_req_if in_ch ();
  fsra_rsp_if out_ch ();

  sector_allocation_tracker sb = new();

  int unsigned idle_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned burst_left = 0;
  int unsigned settings_run = 0;

  always #10 clk = ~clk;

  flash_sector_run_allocator #(
    .NUM_SECTORS (NUM_SECTORS_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Check every result transfer and watch for a hang: any cycle with a
  // transfer on either channel resets the idle counter.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending_results.size());
      $display("flash_sector_run_allocator_tb NOT OK");
      $finish;
    end
  end

  // Gap length: mostly short, a few long.
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result side backpressure: ready stretches and stalls, picked at random.
  initial begin : result_backpressure
    int unsigned span;
    out_ch.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 99) < 65) begin
        span = $urandom_range(1, 24);
        out_ch.ready <= 1'b1;
      end else begin
        span = gap_length();
        out_ch.ready <= 1'b0;
      end
      repeat (span) @(posedge clk);
    end
  end

  // Run length in sectors: mostly short runs, now and then zero or very long.
  function automatic int unsigned pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 0;
    if (roll < 70) return $urandom_range(1, 8);
    if (roll < 90) return $urandom_range(9, 64);
    if (roll < 98) return $urandom_range(65, 300);
    return $urandom_range(301, 1100);
  endfunction

  // Random byte count that rounds up to exactly the given number of sectors, clamped to BYTES_MAX.
  function automatic logic [BYTES_W-1:0] bytes_for(int unsigned sectors);
    longint unsigned unit, val;
    if (sectors == 0) return '0;
    unit = 64'd1 << sb.size_log2;
    val  = longint'(sectors - 1) * unit + $urandom_range(1, int'(unit));
    if (val > BYTES_MAX) return BYTES_MAX;
    return BYTES_W'(val);
  endfunction

  function automatic logic [SEC_W-1:0] random_start(int unsigned lim);
    if (lim == 0) return SEC_W'($urandom_range(0, 1023));
    return SEC_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic req_t make_request(logic [OP_W-1:0] op, int unsigned start,
                                        longint unsigned bytes, bit rsv);
    req_t r;
    r.operation     = op;
    r.start_sector  = SEC_W'(start);
    r.request_bytes = BYTES_W'(bytes);
    r.reserve       = rsv;
    return r;
  endfunction

  // Mostly well-formed traffic: finds, allocations at runs that fit, releases
  // starting on used sectors, release-reserved and counts; the rest is unknown ops and pure noise.
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll, lim, len;
    int          hit;
    lim             = sb.region_limit();
    roll            = $urandom_range(0, 99);
    r.operation     = OP_W'($urandom);
    r.start_sector  = SEC_W'($urandom);
    r.request_bytes = BYTES_W'($urandom);
    r.reserve       = 1'($urandom);
    if (roll < 22) begin
      r.operation     = OP_FIND;
      r.request_bytes = bytes_for(pick_len());
    end else if (roll < 50) begin
      len             = pick_len();
      r.operation     = OP_ALLOC;
      r.request_bytes = bytes_for(len);
      r.reserve       = ($urandom_range(0, 99) < 30);
      hit = (len != 0 && $urandom_range(0, 99) < 70) ? sb.first_free_run(len) : -1;
      r.start_sector  = (hit >= 0) ? SEC_W'(hit) : random_start(lim);
    end else if (roll < 72) begin
      r.operation     = OP_RELEASE;
      r.request_bytes = bytes_for(pick_len());
      hit = ($urandom_range(0, 99) < 70) ? sb.find_sector(SEC_USED, random_start(lim)) : -1;
      r.start_sector  = (hit >= 0) ? SEC_W'(hit) : random_start(lim);
    end else if (roll < 77) begin
      r.operation = OP_REL_RSV;
    end else if (roll < 85) begin
      r.operation = OP_COUNT;
    end else if (roll < 89) begin
      r.operation = OP_W'($urandom_range(5, 7));
    end
    return r;
  endfunction

  // Present one request and hold it until the transfer; valid stays high.
  task automatic send_request(input req_t r);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    requests_sent++;
  endtask

  // Drop valid for a random gap, or keep it up during a burst.
  task automatic pause_input();
    int unsigned gap;
    if (burst_left == 0 && $urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 50);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : gap_length();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Every request answers once, so an empty queue means the block is idle.
  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register settings per phase. Entry 0 is never written: phase 0 runs at the reset
  // value, then tiny and empty regions, a full map at the largest sector size, and back to the reset value.
  logic [CNT_W-1:0]  phase_sectors [7] = '{11'd1024, 11'd37, 11'd0, 11'd1024,
                                          11'd200, 11'd1, 11'd1019};
  logic [LOG2_W-1:0] phase_log2    [7] = '{5'd8, 5'd16, 5'd12, 5'd16,
                                          5'd10, 5'd8, 5'd12};
  int unsigned       phase_items   [7] = '{100, 90, 15, 100, 90, 30, 130};

  initial begin : stimulus
    req_t directed [$];
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings (1019 sectors of 4 KiB).
    directed.push_back(make_request(OP_COUNT, 0, 0, 0));
    directed.push_back(make_request(OP_FIND, 0, 0, 0));                  // zero length
    directed.push_back(make_request(OP_FIND, 0, 1, 0));                  // one byte -> sector 0
    directed.push_back(make_request(OP_ALLOC, 0, RESET_UNIT, 0));
    directed.push_back(make_request(OP_ALLOC, 0, 1, 1));                 // busy sector
    directed.push_back(make_request(OP_ALLOC, 1018, RESET_UNIT, 1));     // ends at the top
    directed.push_back(make_request(OP_ALLOC, 1018, RESET_UNIT + 1, 0)); // one past the top
    directed.push_back(make_request(OP_ALLOC, 1023, BYTES_MAX, 1));
    directed.push_back(make_request(OP_ALLOC, 2, 3 * RESET_UNIT, 1));
    directed.push_back(make_request(OP_FIND, 0, 2 * RESET_UNIT, 0));     // skips the gap at 1
    directed.push_back(make_request(OP_FIND, 0, BYTES_MAX, 0));          // no fitting run
    directed.push_back(make_request(OP_RELEASE, 0, 2 * RESET_UNIT, 0));  // sector 1 already free
    directed.push_back(make_request(OP_RELEASE, 1, 3 * RESET_UNIT, 0));  // hits reserved
    directed.push_back(make_request(OP_RELEASE, 0, 0, 0));
    directed.push_back(make_request(OP_RELEASE, 1015, 5 * RESET_UNIT, 0));
    directed.push_back(make_request(OP_ALLOC, 5, 10 * RESET_UNIT, 0));
    directed.push_back(make_request(OP_RELEASE, 5, 12 * RESET_UNIT, 0)); // partly free run
    directed.push_back(make_request(OP_REL_RSV, 0, 0, 0));
    directed.push_back(make_request(3'd5, 0, RESET_UNIT, 0));
    directed.push_back(make_request(3'd6, 512, 0, 1));
    directed.push_back(make_request(3'd7, 1023, BYTES_MAX, 1));
    directed.push_back(make_request(OP_ALLOC, 0, 1019 * RESET_UNIT, 0)); // whole region
    directed.push_back(make_request(OP_FIND, 0, 1, 0));                  // map full
    directed.push_back(make_request(OP_RELEASE, 0, 1019 * RESET_UNIT, 0));
    directed.push_back(make_request(OP_COUNT, 0, 0, 0));
    foreach (directed[i]) begin
      send_request(directed[i]);
      pause_input();
    end
    settings_run = 1;

    // Random phases; every phase but the first runs on a fresh register setting.
    // Allocations made under one region size stay in the map when the next one shrinks it.
    for (int unsigned p = 0; p < 7; p++) begin
      for (int unsigned n = 0; n < phase_items[p]; n++) begin
        send_request(random_request());
        pause_input();
      end
      in_ch.valid <= 1'b0;
      wait_drained();
      if (p + 1 < 7) begin
        write_register(CFG_SIZE_LOG2, CNT_W'(phase_log2[p + 1]));
        write_register(CFG_DATA_SECTORS, phase_sectors[p + 1]);
        settings_run++;
      end
    end
    wait_drained();
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d requests under %0d register settings, %0d results checked",
             requests_sent, settings_run, sb.checked);
    $display("outcomes: %0d ok, %0d no fit, %0d out of range, %0d busy; %0d mismatches",
             sb.n_ok, sb.n_no_fit, sb.n_range, sb.n_busy, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("flash_sector_run_allocator_tb OK");
    end else begin
      $display("flash_sector_run_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
